@@ design/tec_pkg.sv @@
// Shared types, constants and codes of the tolerance error checker.
package tec_pkg;

   localparam int WORD_W      = 32;
   localparam int SUM_W       = 48;
   localparam int PROD_W      = 49;
   localparam int TOL_W       = 17;
   localparam logic [TOL_W-1:0] TOL_SCALE = 17'd100000;

   localparam int MAX_ITEMS_DEFAULT     = 65536;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int REQ_DATA_W  = 96;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 72;

   // Quotient bits produced per division, one per step.
   localparam int DIV_STEPS   = 32;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_RELATIVE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ABSOLUTE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEVIATION = 2'd2;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EPSILON = 1'd1;

   localparam logic [WORD_W-1:0] EPSILON_RESET = 32'd655;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_RANGE,
      S_TOL,
      S_TOLCMP,
      S_DIV,
      S_ACC,
      S_LAST,
      S_AVG,
      S_FIN
   } tec_state_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] rem_init;
      logic [WORD_W-1:0] low_init;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/tec_divider.sv @@
// Shared restoring divider: one quotient bit per cycle, 32 steps per division.
module tec_divider import tec_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [WORD_W-1:0]     quo_ff, quo_in;
   logic [WORD_W-1:0]     dvs_ff, dvs_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [WORD_W+1:0]     trial;

   // Shift in the next dividend bit and try the subtraction.
   assign trial = {1'b0, rem_ff, quo_ff[WORD_W-1]} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         quo_in  = div_req.low_init;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WORD_W+1]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ design/tolerance_error_checker.sv @@
// Top level of the tolerance error checker: sequencer, accumulators and ports.
// Usage:
//   req channel: one beat per compared value. tdata carries source, golden and
//   deviation values (signed/signed/unsigned Q16.16), tuser the item flags and
//   tlast marks the final beat of a run.
//   rsp channel: one beat per run, issued after the tlast beat, carrying fail,
//   the maximum error, the average error and the sticky NaN flag.
//   csr channel: writes the error mode (index 0) or epsilon (index 1); always
//   ready, write only while no beat is in flight.
// Timing: a beat is taken only in the idle state. Skipped and NaN beats, absolute
//   mode, a zero golden value, a saturating quotient and a zero deviation bypass
//   the divider; any other relative or deviation beat waits for the 32-step shared
//   restoring divider. The last beat then uses the divider for the average (not
//   when it saturates) before the response is raised.
// Reset: mode returns to relative, epsilon to 655, all run state clears, and
//   no response is pending.
// Stall: the response waits in an output register while the next run is
//   already accepted; a further response holds the sequencer until it drains.
module tolerance_error_checker import tec_pkg::*; #(
   parameter int MAX_ITEMS     = MAX_ITEMS_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] source_value, [63:32] golden_value, [95:64] deviation_value
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [0] is_numeric, [1] source_overflow, [2] source_nan, [3] golden_nan
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] fail, [32:1] max_error, [64:33] avg_error, [65] nan_error, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int INT_SHIFT = WORD_W - FRACTION_BITS;

   tec_state_type state_ff, state_in;

   // configuration
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [WORD_W-1:0]        eps_ff, eps_in;

   // captured beat
   logic signed [WORD_W-1:0] src_ff, src_in;
   logic signed [WORD_W-1:0] gold_ff, gold_in;
   logic [WORD_W-1:0]        dev_ff, dev_in;
   logic                     numeric_ff, numeric_in;
   logic                     ovf_ff, ovf_in;
   logic                     snan_ff, snan_in;
   logic                     gnan_ff, gnan_in;
   logic                     last_ff, last_in;

   // per-item working values
   logic [WORD_W-1:0]        diff_ff, diff_in;
   logic [WORD_W-1:0]        divisor_ff, divisor_in;
   logic [WORD_W-1:0]        magm_ff, magm_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [WORD_W-1:0]        err_ff, err_in;
   logic [WORD_W-1:0]        avg_ff, avg_in;

   // run state
   logic [WORD_W-1:0]        max_ff, max_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     nan_ff, nan_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic signed [WORD_W-1:0] s_eff;
   logic signed [WORD_W:0]   diff_wide;
   logic [WORD_W:0]          diff_abs;
   logic [WORD_W:0]          gold_abs;
   logic signed [WORD_W-1:0] m_val;
   logic [WORD_W:0]          m_abs;
   logic [WORD_W-1:0]        range_rem;
   logic                     range_sat;
   logic [SUM_W:0]           sum_add;
   logic [WORD_W-1:0]        avg_hi;
   logic                     fail;

   tec_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Error front end: overflowed source reads as zero.
   assign s_eff     = ovf_ff ? '0 : src_ff;
   assign diff_wide = {s_eff[WORD_W-1], s_eff} - {gold_ff[WORD_W-1], gold_ff};
   assign diff_abs  = diff_wide[WORD_W] ? (WORD_W+1)'(-diff_wide) : diff_wide;
   assign gold_abs  = gold_ff[WORD_W-1] ? (WORD_W+1)'(-{gold_ff[WORD_W-1], gold_ff})
                                        : {1'b0, gold_ff};
   assign m_val     = (s_eff > gold_ff) ? s_eff : gold_ff;
   assign m_abs     = m_val[WORD_W-1] ? (WORD_W+1)'(-{m_val[WORD_W-1], m_val})
                                      : {1'b0, m_val};

   // Quotient overflows 32 bits exactly when the integer part reaches the divisor.
   assign range_rem = diff_ff >> INT_SHIFT;
   assign range_sat = range_rem >= divisor_ff;

   assign sum_add = {1'b0, sum_ff} + (SUM_W+1)'(err_ff);
   assign avg_hi  = WORD_W'(sum_ff[SUM_W-1:WORD_W]);
   assign fail    = max_ff > eps_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      eps_in       = eps_ff;
      src_in       = src_ff;
      gold_in      = gold_ff;
      dev_in       = dev_ff;
      numeric_in   = numeric_ff;
      ovf_in       = ovf_ff;
      snan_in      = snan_ff;
      gnan_in      = gnan_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      divisor_in   = divisor_ff;
      magm_in      = magm_ff;
      prod_in      = prod_ff;
      err_in       = err_ff;
      avg_in       = avg_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      nan_in       = nan_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      req_tready   = 1'b0;

      // register writes land in any state
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:    mode_in = csr_data[MODE_W-1:0];
            CSR_EPSILON: eps_in  = csr_data;
            default:     ;
         endcase
      end

      // drop the response beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               src_in     = req_tdata[WORD_W-1:0];
               gold_in    = req_tdata[2*WORD_W-1:WORD_W];
               dev_in     = req_tdata[3*WORD_W-1:2*WORD_W];
               numeric_in = req_tuser[0];
               ovf_in     = req_tuser[1];
               snan_in    = req_tuser[2];
               gnan_in    = req_tuser[3];
               last_in    = req_tlast;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            if (count_ff < CNT_W'(MAX_ITEMS)) begin
               count_in = count_ff + CNT_W'(1);
            end
            diff_in = diff_abs[WORD_W-1:0];
            magm_in = m_abs[WORD_W-1:0];
            if (!numeric_ff) begin
               state_in = S_LAST;
            end else if (snan_ff || gnan_ff) begin
               nan_in   = 1'b1;
               state_in = S_LAST;
            end else begin
               case (mode_ff)
                  MODE_RELATIVE: begin
                     if (gold_ff == '0) begin
                        err_in   = diff_abs[WORD_W-1:0];
                        state_in = S_ACC;
                     end else begin
                        divisor_in = gold_abs[WORD_W-1:0];
                        state_in   = S_RANGE;
                     end
                  end
                  MODE_DEVIATION: begin
                     if (dev_ff == '0) begin
                        state_in = S_TOL;
                     end else begin
                        divisor_in = dev_ff;
                        state_in   = S_RANGE;
                     end
                  end
                  default: begin
                     err_in   = diff_abs[WORD_W-1:0];
                     state_in = S_ACC;
                  end
               endcase
            end
         end
         S_TOL: begin
            prod_in  = PROD_W'(diff_ff) * PROD_W'(TOL_SCALE);
            state_in = S_TOLCMP;
         end
         S_TOLCMP: begin
            err_in   = (prod_ff <= PROD_W'(magm_ff)) ? '0 : '1;
            state_in = S_ACC;
         end
         S_RANGE: begin
            if (range_sat) begin
               err_in   = '1;
               state_in = S_ACC;
            end else begin
               div_req.start    = 1'b1;
               div_req.rem_init = range_rem;
               div_req.low_init = diff_ff << FRACTION_BITS;
               div_req.divisor  = divisor_ff;
               state_in         = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               err_in   = div_rsp.quotient;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (err_ff > max_ff) begin
               max_in = err_ff;
            end
            sum_in   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            state_in = S_LAST;
         end
         S_LAST: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (avg_hi >= WORD_W'(count_ff)) begin
               avg_in   = '1;
               state_in = S_FIN;
            end else begin
               div_req.start    = 1'b1;
               div_req.rem_init = avg_hi;
               div_req.low_init = sum_ff[WORD_W-1:0];
               div_req.divisor  = WORD_W'(count_ff);
               state_in         = S_AVG;
            end
         end
         S_AVG: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output register is free, then clear the run
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({nan_ff, avg_ff, max_ff, fail});
               max_in       = '0;
               sum_in       = '0;
               count_in     = '0;
               nan_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_RELATIVE;
         eps_ff       <= EPSILON_RESET;
         max_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         nan_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         eps_ff       <= eps_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         nan_ff       <= nan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      gold_ff     <= gold_in;
      dev_ff      <= dev_in;
      numeric_ff  <= numeric_in;
      ovf_ff      <= ovf_in;
      snan_ff     <= snan_in;
      gnan_ff     <= gnan_in;
      last_ff     <= last_in;
      diff_ff     <= diff_in;
      divisor_ff  <= divisor_in;
      magm_ff     <= magm_in;
      prod_ff     <= prod_in;
      err_ff      <= err_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The divider only finishes while the sequencer waits for it.
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV || state_ff == S_AVG))
      else $error("divider finished outside a division state");

   // The item count saturates at the limit.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond limit");

   // Issuing a response clears the run state and raises the response beat.
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && state_in == S_IDLE)
      |=> (count_ff == '0 && sum_ff == '0 && max_ff == '0 && !nan_ff && rsp_tvalid))
      else $error("run state not cleared after response");
`endif

endmodule

@@ test/tec_checker.sv @@
// Channel watcher for the tolerance error checker: predicts each run summary and compares it.
module tec_checker import tec_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data,
   output int                     mismatches,
   output int                     summaries_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int USER_NUMERIC  = 0;
   localparam int USER_OVERFLOW = 1;
   localparam int USER_SRC_NAN  = 2;
   localparam int USER_GOLD_NAN = 3;

   localparam logic [63:0]      ERR_CEIL = 64'hFFFF_FFFF;
   localparam logic [SUM_W-1:0] SUM_CEIL = '1;

   typedef struct {
      logic              fail;
      logic [WORD_W-1:0] max_error;
      logic [WORD_W-1:0] avg_error;
      logic              nan_error;
   } run_summary_type;

   logic [MODE_W-1:0] err_mode;
   logic [WORD_W-1:0] eps;
   logic [WORD_W-1:0] max_seen;
   logic [SUM_W-1:0]  err_sum;
   logic [TOL_W-1:0]  n_items;
   logic              nan_seen;
   run_summary_type   summaries[$];
   int                errs = 0;

   function automatic logic [WORD_W-1:0] clip32(input logic [63:0] v);
      return (v > ERR_CEIL) ? WORD_W'(ERR_CEIL) : v[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] scaled_quotient(input logic [63:0] diff,
                                                         input logic [63:0] divisor);
      if (divisor == 0) return '1;
      return clip32((diff << FRACTION_BITS_DEFAULT) / divisor);
   endfunction

   function automatic logic [WORD_W-1:0] item_error(input logic [MODE_W-1:0] mode,
                                                    input longint s, input longint g,
                                                    input logic [WORD_W-1:0] dev);
      longint      d;
      longint      m;
      logic [63:0] diff;
      logic [63:0] peak;
      logic [63:0] gmag;
      d    = s - g;
      diff = (d < 0) ? -d : d;
      m    = (s > g) ? s : g;
      peak = (m < 0) ? -m : m;
      gmag = (g < 0) ? -g : g;
      case (mode)
         MODE_RELATIVE: begin
            if (g == 0) return clip32(diff);
            return scaled_quotient(diff, gmag);
         end
         MODE_DEVIATION: begin
            // zero deviation: pass only within ten parts per million of the larger value
            if (dev == 0) return (diff * TOL_SCALE <= peak) ? '0 : '1;
            return scaled_quotient(diff, {32'd0, dev});
         end
         default: return clip32(diff);
      endcase
   endfunction

   always @(posedge clock) begin : watch
      logic [WORD_W-1:0] err;
      longint            s;
      longint            g;
      logic [SUM_W:0]    sum_next;
      run_summary_type   want;
      if (reset) begin
         err_mode = MODE_RELATIVE;
         eps      = EPSILON_RESET;
         max_seen = '0;
         err_sum  = '0;
         n_items  = '0;
         nan_seen = 1'b0;
      end else begin
         // compare before predicting: a summary leaving now belongs to an earlier run
         if (rsp_tvalid && rsp_tready) begin
            if (summaries.size() == 0) begin
               $error("response beat with no run summary outstanding");
               errs++;
            end else begin
               want = summaries.pop_front();
               if (rsp_tdata[0] !== want.fail) begin
                  $error("fail: expected %0b, actual %0b", want.fail, rsp_tdata[0]);
                  errs++;
               end
               if (rsp_tdata[32:1] !== want.max_error) begin
                  $error("max_error: expected %h, actual %h", want.max_error, rsp_tdata[32:1]);
                  errs++;
               end
               if (rsp_tdata[64:33] !== want.avg_error) begin
                  $error("avg_error: expected %h, actual %h", want.avg_error, rsp_tdata[64:33]);
                  errs++;
               end
               if (rsp_tdata[65] !== want.nan_error) begin
                  $error("nan_error: expected %0b, actual %0b", want.nan_error, rsp_tdata[65]);
                  errs++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:    err_mode = csr_data[MODE_W-1:0];
               CSR_EPSILON: eps      = csr_data;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            if (n_items < MAX_ITEMS_DEFAULT) n_items++;
            if (req_tuser[USER_NUMERIC]) begin
               if (req_tuser[USER_SRC_NAN] || req_tuser[USER_GOLD_NAN]) begin
                  nan_seen = 1'b1;
               end else begin
                  s = $signed(req_tdata[WORD_W-1:0]);
                  g = $signed(req_tdata[2*WORD_W-1:WORD_W]);
                  if (req_tuser[USER_OVERFLOW]) s = 0;
                  err = item_error(err_mode, s, g, req_tdata[3*WORD_W-1:2*WORD_W]);
                  if (err > max_seen) max_seen = err;
                  sum_next = err_sum + err;
                  err_sum  = (sum_next > SUM_CEIL) ? SUM_CEIL : sum_next[SUM_W-1:0];
               end
            end
            if (req_tlast) begin
               want.fail      = (max_seen > eps);
               want.max_error = max_seen;
               want.avg_error = (n_items != 0) ? clip32(64'(err_sum) / 64'(n_items)) : '0;
               want.nan_error = nan_seen;
               summaries.insert(summaries.size(), want);
               max_seen = '0;
               err_sum  = '0;
               n_items  = '0;
               nan_seen = 1'b0;
            end
         end
      end
      mismatches    <= errs;
      summaries_due <= summaries.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the tolerance error checker testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tec_pkg::*;

   // The package names three modes; the fourth code must behave like absolute.
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   localparam int     RESET_CYCLES   = 3;
   // Longest internal activity: a divided item plus the closing average, with margin.
   localparam int     SETTLE_CYCLES  = 100;
   localparam int     HOLD_CYCLES    = 600;
   localparam int     RANDOM_ITEMS   = 2000;
   localparam int     PRESSURE_RUNS  = 12;
   // A long run of beats, mostly at the widest difference, at full rate.
   localparam int     LONG_RUN_ITEMS = 120;
   localparam longint CYCLE_LIMIT    = 4_000_000;

   typedef struct {
      logic [WORD_W-1:0] src;
      logic [WORD_W-1:0] gold;
      logic [WORD_W-1:0] dev;
      logic              numeric;
      logic              ovf;
      logic              snan;
      logic              gnan;
   } sample_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_data;

   int     mismatch_count;
   int     due;
   bit     quiet       = 1'b0;
   int     holds_asked = 0;
   longint cycle_count = 0;

   tolerance_error_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tec_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatch_count),
      .summaries_due (due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: end the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none at all in quiet stretches.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type pair(input logic [WORD_W-1:0] src,
                                       input logic [WORD_W-1:0] gold,
                                       input logic [WORD_W-1:0] dev);
      sample_type x;
      x.src     = src;
      x.gold    = gold;
      x.dev     = dev;
      x.numeric = 1'b1;
      x.ovf     = 1'b0;
      x.snan    = 1'b0;
      x.gnan    = 1'b0;
      return x;
   endfunction

   // Bias values towards the rails, zero and small magnitudes up to eight.
   function automatic logic [WORD_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
         2:       return 32'h8000_0000 + $urandom_range(0, 3);
         3:       return '0;
         default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type x;
      x.src = rand_value();
      // golden often equal or very close, so the zero-deviation tolerance is hit both ways
      case ($urandom_range(0, 3))
         0:       x.gold = x.src;
         1:       x.gold = x.src + $urandom_range(0, 64) - 32;
         default: x.gold = rand_value();
      endcase
      case ($urandom_range(0, 4))
         0:       x.dev = '0;
         1:       x.dev = $urandom();
         2:       x.dev = '1;
         default: x.dev = $urandom_range(1, 32'h0002_0000);
      endcase
      x.numeric = ($urandom_range(0, 9) != 0);
      x.ovf     = ($urandom_range(0, 9) == 0);
      x.snan    = ($urandom_range(0, 19) == 0);
      x.gnan    = ($urandom_range(0, 19) == 0);
      return x;
   endfunction

   // Offer one beat, optionally after an idle gap, and hold it until taken.
   task automatic send(input sample_type x, input logic last);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {x.dev, x.gold, x.src};
      req_tuser  <= {x.gnan, x.snan, x.ovf, x.numeric};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, wait for every outstanding summary, then let the divider settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] eps);
      write_reg(CSR_MODE, mode);
      write_reg(CSR_EPSILON, eps);
   endtask

   // Response side: random back-pressure, plus a long hold-off whenever one is asked for.
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_asked != 0) begin
            holds_asked--;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            n = idle_cycles();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   initial begin
      sample_type        x;
      int                done_random;
      int                runs;
      int                len;
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] eps;
      done_random = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_MODE;
      csr_data   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Relative mode at the reset tolerance.
      setup(MODE_RELATIVE, EPSILON_RESET);
      send(pair(32'h7FFF_FFFF, 32'h8000_0000, '0), 1'b0);   // widest difference, golden at the rail
      send(pair(32'h8000_0000, 32'h0000_0000, '0), 1'b0);   // golden zero: error is the plain difference
      send(pair(32'h0001_8000, 32'h0001_0000, '0), 1'b0);   // 1.5 against 1.0
      send(pair(32'h0000_0000, 32'h0000_0000, '0), 1'b0);
      x = pair(32'hFFFF_FFFF, 32'h0003_0000, '0);
      x.ovf = 1'b1;                                         // overflowed source reads as zero
      send(x, 1'b0);
      x = pair(32'h1234_5678, 32'h0001_0000, '0);
      x.snan = 1'b1;
      send(x, 1'b0);
      x = pair(32'h0001_0000, 32'h8765_4321, '0);
      x.gnan = 1'b1;
      send(x, 1'b0);
      x = pair(32'h8000_0000, 32'h7FFF_FFFF, '1);
      x.numeric = 1'b0;                                     // counted but skipped
      send(x, 1'b1);
      send(pair(32'h0000_0000, 32'h0001_0000, '0), 1'b1);   // run of a single beat
      drain();

      // Absolute mode with zero tolerance.
      setup(MODE_ABSOLUTE, '0);
      send(pair(32'h7FFF_FFFF, 32'h8000_0000, '1), 1'b0);
      send(pair(32'h8000_0000, 32'h7FFF_FFFF, '0), 1'b0);
      send(pair(32'h1234_5678, 32'h1234_5678, '0), 1'b1);
      drain();

      // Deviation mode with the widest tolerance.
      setup(MODE_DEVIATION, '1);
      send(pair(32'h0064_0000, 32'h0064_0000, '0), 1'b0);   // zero deviation, exact match
      send(pair(32'h7FFF_FFFF, 32'h7FFF_F000, '0), 1'b0);   // zero deviation, inside tolerance
      send(pair(32'hFC18_0000, 32'hFC18_0001, '0), 1'b0);   // both negative, inside tolerance
      send(pair(32'h0001_0000, 32'h0000_0000, '0), 1'b0);   // zero deviation, outside tolerance
      send(pair(32'h7FFF_FFFF, 32'h8000_0000, '1), 1'b0);
      send(pair(32'h7FFF_FFFF, 32'h8000_0000, 32'd1), 1'b1); // quotient saturates
      drain();

      // The unused mode code.
      setup(MODE_RESERVED, $urandom());
      send(pair(32'hDEAD_BEEF, 32'h1234_5678, '0), 1'b0);
      send(pair(32'h0000_0000, 32'h8000_0000, '0), 1'b1);
      drain();

      // Random phases: fresh settings, a handful of runs, then a full drain.
      while (done_random < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0:       mode = MODE_RELATIVE;
            1:       mode = MODE_ABSOLUTE;
            2:       mode = MODE_DEVIATION;
            default: mode = MODE_RESERVED;
         endcase
         case ($urandom_range(0, 4))
            0:       eps = '0;
            1:       eps = '1;
            2:       eps = EPSILON_RESET;
            3:       eps = $urandom_range(0, 32'h0004_0000);
            default: eps = $urandom();
         endcase
         setup(mode, eps);
         runs = $urandom_range(2, 10);
         for (int r = 0; r < runs; r++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
            for (int k = 0; k < len; k++) begin
               send(rand_sample(), k == len - 1);
               done_random++;
            end
         end
         drain();
      end

      // Back-pressure: hold the response side while single-beat runs keep coming,
      // so summaries pile up and the request side has to stall.
      quiet = 1'b1;
      setup(MODE_ABSOLUTE, EPSILON_RESET);
      holds_asked++;
      for (int r = 0; r < PRESSURE_RUNS; r++) send(rand_sample(), 1'b1);
      drain();

      // One long run at full rate, mostly at the widest difference.
      setup(MODE_ABSOLUTE, 32'hFFFF_FFFE);
      for (int k = 0; k < LONG_RUN_ITEMS; k++) begin
         if (k % 40 == 39) x = rand_sample();
         else x = pair(32'h7FFF_FFFF, 32'h8000_0000, $urandom());
         send(x, k == LONG_RUN_ITEMS - 1);
      end
      drain();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/tec_pkg.sv
design/tec_divider.sv
design/tolerance_error_checker.sv
test/tec_checker.sv
test/testbench.sv
